// ===== sv/assert_macros.svh =====
// Assertion macros shared by the gated tone noise generator files.
// Needs nothing else; each macro checks on the rising clock edge outside reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, reset disables the check.
`define GTN_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("gtn assertion failed");

// Next-cycle implication, reset disables the check.
`define GTN_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("gtn assertion failed");

`endif

// ===== sv/gtn_pkg.sv =====
// Package of the gated tone noise generator: sizes, constants, types,
// divisor table and small helper functions. Depends on nothing.
package gtn_pkg;

    localparam int CHANNELS     = 3;
    localparam int COUNTER_BITS = 17;

    localparam int CNT_W     = COUNTER_BITS;
    localparam int PER_W     = 16;
    localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int DRAW_W    = 15;
    localparam int DIV_W     = 12;
    localparam int RCP_SHIFT = 27;
    localparam int RCP_W     = RCP_SHIFT + 1;
    localparam int TOTAL_W   = 17;
    localparam int ADDR_W    = 3;
    localparam int DATA_W    = 32;

    // Rounded-up reciprocal; with a 15-bit dividend and a divisor below 4096 the
    // product shifted right by RCP_SHIFT is the exact quotient.
    function automatic logic [RCP_W-1:0] gtn_recip_of(int unsigned d);
        return RCP_W'(((64'd1 << RCP_SHIFT) + 64'(d) - 64'd1) / 64'(d));
    endfunction

    localparam logic [31:0]        LCG_MUL      = 32'd1103515245;
    localparam logic [31:0]        LCG_INC      = 32'd12345;
    localparam logic [31:0]        LCG_SEED     = 32'd1;
    localparam logic [TOTAL_W-1:0] TOTAL_WRAP   = TOTAL_W'(65535);
    localparam logic [DIV_W-1:0]   TOTAL_DIV    = DIV_W'(100);
    localparam logic [RCP_W-1:0]   TOTAL_RCP    = gtn_recip_of(100);
    localparam logic [PER_W-1:0]   PRESCALE_RST = PER_W'(5);

    localparam logic [0:0] REG_PLAY_PRESCALE = 1'b0;

    localparam logic [1:0] FLD_TONE   = 2'd0;
    localparam logic [1:0] FLD_LENGTH = 2'd1;
    localparam logic [1:0] FLD_PLAY   = 2'd2;

    typedef enum logic [1:0] {
        SET_A = 2'd0,
        SET_B = 2'd1,
        SET_C = 2'd2,
        SET_D = 2'd3
    } t_set;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DRAW,
        S_DIV,
        S_STORE,
        S_SET
    } t_state;

    typedef struct packed {
        logic            tick;
        logic            wrap;
        logic            draw;
        logic            div_step;
        logic            store;
        logic            set_latch;
        logic            is_total;
        logic [CH_W-1:0] ch;
        logic [1:0]      fld;
        logic            move;
    } t_cmd;

    typedef struct packed {
        logic in_ready;
        logic out_valid;
        logic pend;
    } t_stat;

    function automatic logic [RCP_W-1:0] gtn_recip(t_set set, logic [1:0] row,
                                                  logic [1:0] fld);
        logic [RCP_W-1:0] d;
        d = gtn_recip_of(1);
        case (set)
            SET_A: begin
                case (fld)
                    FLD_TONE:   d = (row == 2'd0) ? gtn_recip_of(200) : gtn_recip_of(400);
                    FLD_LENGTH: d = gtn_recip_of(5);
                    default:    d = gtn_recip_of(1);
                endcase
            end
            SET_B: begin
                case (fld)
                    FLD_TONE:   d = gtn_recip_of(200);
                    FLD_LENGTH: d = gtn_recip_of(20);
                    default:    d = gtn_recip_of(5);
                endcase
            end
            SET_C: begin
                case (row)
                    2'd0: begin
                        case (fld)
                            FLD_TONE:   d = gtn_recip_of(2500);
                            FLD_LENGTH: d = gtn_recip_of(12);
                            default:    d = gtn_recip_of(5);
                        endcase
                    end
                    2'd1: begin
                        case (fld)
                            FLD_TONE:   d = gtn_recip_of(10);
                            FLD_LENGTH: d = gtn_recip_of(8);
                            default:    d = gtn_recip_of(1);
                        endcase
                    end
                    default: begin
                        case (fld)
                            FLD_TONE:   d = gtn_recip_of(1000);
                            FLD_LENGTH: d = gtn_recip_of(1);
                            default:    d = gtn_recip_of(15);
                        endcase
                    end
                endcase
            end
            default: begin
                case (row)
                    2'd0: begin
                        case (fld)
                            FLD_TONE:   d = gtn_recip_of(200);
                            FLD_LENGTH: d = gtn_recip_of(4);
                            default:    d = gtn_recip_of(1);
                        endcase
                    end
                    2'd1: begin
                        case (fld)
                            FLD_TONE:   d = gtn_recip_of(800);
                            FLD_LENGTH: d = gtn_recip_of(8);
                            default:    d = gtn_recip_of(1);
                        endcase
                    end
                    default: begin
                        case (fld)
                            FLD_TONE:   d = gtn_recip_of(1000);
                            FLD_LENGTH: d = gtn_recip_of(10);
                            default:    d = gtn_recip_of(1);
                        endcase
                    end
                endcase
            end
        endcase
        return d;
    endfunction

    // Since 2 is -1 modulo 3, even bits count once and odd bits twice.
    function automatic logic gtn_div3(logic [TOTAL_W-1:0] v);
        logic [4:0] s;
        logic       z;
        s = '0;
        for (int b = 0; b < TOTAL_W; b++) begin
            s = s + ((b % 2 == 0) ? 5'(v[b]) : 5'({v[b], 1'b0}));
        end
        case (s) inside
            5'd0, 5'd3, 5'd6, 5'd9, 5'd12, 5'd15, 5'd18, 5'd21, 5'd24: z = 1'b1;
            default: z = 1'b0;
        endcase
        return z;
    endfunction

    function automatic t_set gtn_pick_set(logic [TOTAL_W-1:0] v);
        t_set s;
        if (v[1:0] == 2'b00) begin
            s = SET_A;
        end else if (v[0] == 1'b0) begin
            s = SET_B;
        end else if (gtn_div3(v)) begin
            s = SET_C;
        end else begin
            s = SET_D;
        end
        return s;
    endfunction

    function automatic logic [PER_W-1:0] gtn_tone_rst(int c);
        return (c == 0) ? PER_W'(1000) : PER_W'(500);
    endfunction

    function automatic logic [PER_W-1:0] gtn_length_rst(int c);
        return (c == 0) ? PER_W'(50000) : PER_W'(10000);
    endfunction

    function automatic logic [PER_W-1:0] gtn_play_rst(int c);
        return (c == 0) ? PER_W'(60000) : PER_W'(40000);
    endfunction

endpackage

// ===== sv/gtn_in_if.sv =====
// Input request channel of the gated tone noise generator: one tick with
// its button flag. Depends on nothing.
interface gtn_in_if;
    logic valid;
    logic ready;
    logic button_pressed;

    modport source (output valid, output button_pressed, input ready);
    modport sink   (input valid, input button_pressed, output ready);
endinterface

// ===== sv/gtn_out_if.sv =====
// Output request channel of the gated tone noise generator: one noise
// level per tick. Depends on nothing.
interface gtn_out_if;
    logic valid;
    logic ready;
    logic noise_level;

    modport source (output valid, output noise_level, input ready);
    modport sink   (input valid, input noise_level, output ready);
endinterface

// ===== sv/gtn_ctrl.sv =====
// Controller of the gated tone noise generator: handshakes, result hand-off
// and the press sequence of draws and divisions. Depends on gtn_pkg.
module gtn_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_button,
    input  logic          i_out_ready,
    output gtn_pkg::t_cmd o_cmd,
    output gtn_pkg::t_stat o_stat
);
    import gtn_pkg::*;

    t_state            r_state, n_state;
    logic              r_pend, n_pend;
    logic              r_out_valid, n_out_valid;
    logic [CH_W-1:0]   r_ch, n_ch;
    logic [1:0]        r_fld, n_fld;
    logic              r_is_total, n_is_total;

    logic in_ready;
    logic accept;
    logic move;
    logic last_store;

    assign in_ready   = (r_state == S_IDLE) && !r_pend;
    assign accept     = i_in_valid && in_ready;
    assign move       = r_pend && (!r_out_valid || i_out_ready);
    assign last_store = (r_ch == '0) && (r_fld == FLD_PLAY);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept && i_button) begin
                    n_state = S_DRAW;
                end
            end
            S_DRAW: n_state = S_DIV;
            S_DIV: n_state = S_STORE;
            S_STORE: begin
                if (r_is_total) begin
                    n_state = S_SET;
                end else if (last_store) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_DRAW;
                end
            end
            S_SET: n_state = S_DRAW;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_pend      = r_pend;
        n_out_valid = r_out_valid;
        n_ch        = r_ch;
        n_fld       = r_fld;
        n_is_total  = r_is_total;
        if (accept) begin
            n_pend = 1'b1;
        end else if (move) begin
            n_pend = 1'b0;
        end
        if (move) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (accept && i_button) begin
            n_is_total = 1'b1;
            n_ch       = CH_W'(CHANNELS - 1);
            n_fld      = FLD_TONE;
        end
        if (r_state == S_STORE && !r_is_total) begin
            if (r_fld == FLD_PLAY) begin
                n_fld = FLD_TONE;
                n_ch  = r_ch - 1'b1;
            end else begin
                n_fld = r_fld + 1'b1;
            end
        end
        if (r_state == S_SET) begin
            n_is_total = 1'b0;
        end
    end

    always_comb begin
        o_cmd.tick      = accept;
        o_cmd.wrap      = accept && i_button;
        o_cmd.draw      = (r_state == S_DRAW);
        o_cmd.div_step  = (r_state == S_DIV);
        o_cmd.store     = (r_state == S_STORE);
        o_cmd.set_latch = (r_state == S_SET);
        o_cmd.is_total  = r_is_total;
        o_cmd.ch        = r_ch;
        o_cmd.fld       = r_fld;
        o_cmd.move      = move;
        o_stat.in_ready  = in_ready;
        o_stat.out_valid = r_out_valid;
        o_stat.pend      = r_pend;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
            r_ch        <= '0;
            r_fld       <= FLD_TONE;
            r_is_total  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
            r_ch        <= n_ch;
            r_fld       <= n_fld;
            r_is_total  <= n_is_total;
        end
    end

endmodule

// ===== sv/gtn_datapath.sv =====
// Datapath of the gated tone noise generator: channel gate lanes, LCG,
// shared reciprocal multiplier and press bookkeeping. Depends on gtn_pkg.
module gtn_datapath (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  gtn_pkg::t_cmd             i_cmd,
    input  logic [gtn_pkg::PER_W-1:0] i_prescale,
    output logic                      o_level
);
    import gtn_pkg::*;

    logic [CHANNELS-1:0] r_tone_lvl, n_tone_lvl;
    logic [CHANNELS-1:0] r_len_gate, n_len_gate;
    logic [CHANNELS-1:0] r_play_gate, n_play_gate;
    logic [PER_W-1:0]    r_tone_per [CHANNELS];
    logic [PER_W-1:0]    r_len_per  [CHANNELS];
    logic [PER_W-1:0]    r_play_per [CHANNELS];
    logic [CNT_W-1:0]    r_tone_cnt [CHANNELS];
    logic [CNT_W-1:0]    n_tone_cnt [CHANNELS];
    logic [CNT_W-1:0]    r_len_cnt  [CHANNELS];
    logic [CNT_W-1:0]    n_len_cnt  [CHANNELS];
    logic [CNT_W-1:0]    r_play_cnt [CHANNELS];
    logic [CNT_W-1:0]    n_play_cnt [CHANNELS];
    logic [CNT_W-1:0]    r_pre_cnt  [CHANNELS];
    logic [CNT_W-1:0]    n_pre_cnt  [CHANNELS];

    logic [TOTAL_W-1:0] r_total;
    logic [31:0]        r_lcg;
    t_set               r_set;
    logic [DRAW_W-1:0]  r_div_q;
    logic [RCP_W-1:0]   r_div_rcp;
    logic               r_pend_level;
    logic               r_out_level;

    logic [31:0]              lcg_next;
    logic [DRAW_W+RCP_W-1:0]  product;
    logic [1:0]               row;
    logic [RCP_W-1:0]         recip;
    logic                     level;

    always_comb begin
        for (int c = 0; c < CHANNELS; c++) begin
            n_tone_lvl[c]  = r_tone_lvl[c];
            n_len_gate[c]  = r_len_gate[c];
            n_play_gate[c] = r_play_gate[c];
            n_tone_cnt[c]  = r_tone_cnt[c];
            n_len_cnt[c]   = r_len_cnt[c];
            n_play_cnt[c]  = r_play_cnt[c];
            n_pre_cnt[c]   = r_pre_cnt[c];
            if (n_play_cnt[c] >= CNT_W'(r_play_per[c])) begin
                n_play_gate[c] = ~r_play_gate[c];
                n_play_cnt[c]  = '0;
            end
            if (r_pre_cnt[c] >= CNT_W'(i_prescale)) begin
                n_play_cnt[c] = n_play_cnt[c] + 1'b1;
                n_pre_cnt[c]  = '0;
            end
            n_pre_cnt[c] = n_pre_cnt[c] + 1'b1;
            if (!n_play_gate[c]) begin
                n_tone_lvl[c] = 1'b0;
            end else begin
                if (r_len_cnt[c] >= CNT_W'(r_len_per[c])) begin
                    n_len_gate[c] = ~r_len_gate[c];
                    n_len_cnt[c]  = '0;
                end
                n_len_cnt[c] = n_len_cnt[c] + 1'b1;
                if (!n_len_gate[c]) begin
                    n_tone_lvl[c] = 1'b0;
                end else begin
                    if (r_tone_cnt[c] >= CNT_W'(r_tone_per[c])) begin
                        n_tone_lvl[c] = ~r_tone_lvl[c];
                        n_tone_cnt[c] = '0;
                    end
                    n_tone_cnt[c] = n_tone_cnt[c] + 1'b1;
                end
            end
        end
        level = ^n_tone_lvl;
    end

    assign lcg_next = r_lcg * LCG_MUL + LCG_INC;
    assign row      = (int'(i_cmd.ch) > 2) ? 2'd2 : 2'(i_cmd.ch);
    assign recip    = i_cmd.is_total ? TOTAL_RCP : gtn_recip(r_set, row, i_cmd.fld);
    assign product  = (DRAW_W + RCP_W)'(r_div_q) * (DRAW_W + RCP_W)'(r_div_rcp);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CHANNELS; c++) begin
                r_tone_per[c] <= gtn_tone_rst(c);
                r_len_per[c]  <= gtn_length_rst(c);
                r_play_per[c] <= gtn_play_rst(c);
                r_tone_cnt[c] <= '0;
                r_len_cnt[c]  <= '0;
                r_play_cnt[c] <= '0;
                r_pre_cnt[c]  <= '0;
            end
            r_tone_lvl  <= '1;
            r_len_gate  <= '0;
            r_play_gate <= '0;
            r_total     <= '0;
            r_lcg       <= LCG_SEED;
            r_set       <= SET_A;
        end else begin
            if (i_cmd.tick) begin
                r_tone_lvl  <= n_tone_lvl;
                r_len_gate  <= n_len_gate;
                r_play_gate <= n_play_gate;
                for (int c = 0; c < CHANNELS; c++) begin
                    r_tone_cnt[c] <= n_tone_cnt[c];
                    r_len_cnt[c]  <= n_len_cnt[c];
                    r_play_cnt[c] <= n_play_cnt[c];
                    r_pre_cnt[c]  <= n_pre_cnt[c];
                end
            end
            if (i_cmd.wrap && (r_total > TOTAL_WRAP)) begin
                r_total <= '0;
            end
            if (i_cmd.draw) begin
                r_lcg <= lcg_next;
            end
            if (i_cmd.store && i_cmd.is_total) begin
                r_total <= r_total + TOTAL_W'(r_div_q);
            end
            if (i_cmd.store && !i_cmd.is_total) begin
                for (int c = 0; c < CHANNELS; c++) begin
                    if (i_cmd.ch == CH_W'(c)) begin
                        case (i_cmd.fld)
                            FLD_TONE:   r_tone_per[c] <= PER_W'(r_div_q);
                            FLD_LENGTH: r_len_per[c]  <= PER_W'(r_div_q);
                            default:    r_play_per[c] <= PER_W'(r_div_q);
                        endcase
                    end
                end
            end
            if (i_cmd.set_latch) begin
                r_set <= gtn_pick_set(r_total);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.draw) begin
            r_div_q   <= lcg_next[30:16];
            r_div_rcp <= recip;
        end else if (i_cmd.div_step) begin
            r_div_q <= product[RCP_SHIFT +: DRAW_W];
        end
        if (i_cmd.tick) begin
            r_pend_level <= level;
        end
        if (i_cmd.move) begin
            r_out_level <= r_pend_level;
        end
    end

    assign o_level = r_out_level;

endmodule

// ===== sv/gated_tone_noise_generator_unit.sv =====
// Gated tone noise generator, top level. Each request on i_in is one audio
// tick with a button flag; each tick gives exactly one request on o_out that
// carries the XOR of the three gated channel tones after that tick.
// An accepted tick's level is registered as pending and then moved into the
// output register once o_out is free; a new tick waits while one is pending.
// A tick with the button flag starts a reload that keeps i_in stalled until
// it ends: ten LCG draws, each through S_DRAW (32-bit LCG multiplier), S_DIV
// (shared reciprocal multiplier that divides by the table constant) and
// S_STORE, plus S_SET after the first draw to pick the set.
// The result of the pressed tick is delivered while the reload runs.
// One held result and one more pending level are buffered; when the
// receiver stalls, i_in stops after that and nothing is lost.
// The APB port holds play_prescale at byte address 0; pready is always high.
// A synchronous active-low reset restores all periods, gates, counters,
// the LCG seed and a prescale of 5.
`include "assert_macros.svh"

module gated_tone_noise_generator_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    gtn_in_if.sink                      i_in,
    gtn_out_if.source                   o_out,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [gtn_pkg::ADDR_W-1:0]  paddr,
    input  logic [gtn_pkg::DATA_W-1:0]  pwdata,
    output logic [gtn_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);
    import gtn_pkg::*;

    t_cmd             cmd;
    t_stat            stat;
    logic [PER_W-1:0] r_prescale;
    logic             level;
    logic             cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_PLAY_PRESCALE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prescale <= PRESCALE_RST;
        end else if (cfg_write) begin
            r_prescale <= pwdata[PER_W-1:0];
        end
    end

    always_comb begin
        if (paddr[2] == REG_PLAY_PRESCALE) begin
            prdata = DATA_W'(r_prescale);
        end else begin
            prdata = '0;
        end
    end

    gtn_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_button    (i_in.button_pressed),
        .i_out_ready (o_out.ready),
        .o_cmd       (cmd),
        .o_stat      (stat)
    );

    gtn_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_prescale (r_prescale),
        .o_level    (level)
    );

    assign i_in.ready        = stat.in_ready;
    assign o_out.valid       = stat.out_valid;
    assign o_out.noise_level = level;

    `GTN_ASSERT_NXT(a_press_stalls, i_clk, i_rst_n,
        i_in.valid && i_in.ready && i_in.button_pressed, !i_in.ready)
    `GTN_ASSERT_IMP(a_out_from_pend, i_clk, i_rst_n, $rose(o_out.valid), $past(stat.pend))
    `GTN_ASSERT_NXT(a_draw_then_div, i_clk, i_rst_n, cmd.draw, cmd.div_step)

endmodule

// ===== tb/gtn_noise_checker.sv =====
// Checker for the gated tone noise generator: watches the tick, level and APB
// channels, predicts every noise level and compares it with the delivered one.
// Depends on gtn_pkg and the gtn_in_if and gtn_out_if interfaces.
module gtn_noise_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    gtn_in_if                           i_tick,
    gtn_out_if                          i_level,
    input  logic                        i_psel,
    input  logic                        i_penable,
    input  logic                        i_pwrite,
    input  logic [gtn_pkg::ADDR_W-1:0]  i_paddr,
    input  logic [gtn_pkg::DATA_W-1:0]  i_pwdata,
    input  logic [gtn_pkg::DATA_W-1:0]  i_prdata,
    input  logic                        i_pready,
    output int                          o_fail_count,
    output int                          o_pending
);
    import gtn_pkg::*;

    localparam logic [ADDR_W-1:0] PRESCALE_ADDR = ADDR_W'({REG_PLAY_PRESCALE, 2'b00});

    // Divisors per set and channel row, each row holding tone, length and play.
    localparam int unsigned DIVISORS [4][3][3] = '{
        '{'{200, 5, 1},   '{400, 5, 1}, '{400, 5, 1}},
        '{'{200, 20, 5},  '{200, 20, 5}, '{200, 20, 5}},
        '{'{2500, 12, 5}, '{10, 8, 1},  '{1000, 1, 15}},
        '{'{200, 4, 1},   '{800, 8, 1}, '{1000, 10, 1}}
    };

    logic [PER_W-1:0]   prescale;
    logic               tone_lvl  [CHANNELS];
    logic               len_gate  [CHANNELS];
    logic               play_gate [CHANNELS];
    logic [PER_W-1:0]   tone_per  [CHANNELS];
    logic [PER_W-1:0]   len_per   [CHANNELS];
    logic [PER_W-1:0]   play_per  [CHANNELS];
    logic [CNT_W-1:0]   tone_cnt  [CHANNELS];
    logic [CNT_W-1:0]   len_cnt   [CHANNELS];
    logic [CNT_W-1:0]   play_cnt  [CHANNELS];
    logic [CNT_W-1:0]   pre_cnt   [CHANNELS];
    logic [TOTAL_W-1:0] press_total;
    logic [31:0]        lcg;
    logic               expected_levels [$];
    logic               predicted;
    logic               wanted;

    task automatic report_mismatch(input string what, input int want, input int got);
        o_fail_count++;
        if (o_fail_count <= 10) begin
            $display("mismatch on %s at %0t: expected %0d, got %0d", what, $realtime, want, got);
        end
    endtask

    task automatic restore_reset();
        prescale = PRESCALE_RST;
        for (int c = 0; c < CHANNELS; c++) begin
            tone_lvl[c]  = 1'b1;
            len_gate[c]  = 1'b0;
            play_gate[c] = 1'b0;
            tone_per[c]  = (c == 0) ? PER_W'(1000) : PER_W'(500);
            len_per[c]   = (c == 0) ? PER_W'(50000) : PER_W'(10000);
            play_per[c]  = (c == 0) ? PER_W'(60000) : PER_W'(40000);
            tone_cnt[c]  = '0;
            len_cnt[c]   = '0;
            play_cnt[c]  = '0;
            pre_cnt[c]   = '0;
        end
        press_total = '0;
        lcg         = LCG_SEED;
    endtask

    task automatic draw_value(output logic [DRAW_W-1:0] value);
        lcg   = lcg * LCG_MUL + LCG_INC;
        value = lcg[30:16];
    endtask

    task automatic tick_channels(output logic level);
        level = 1'b0;
        for (int c = 0; c < CHANNELS; c++) begin
            if (play_cnt[c] >= CNT_W'(play_per[c])) begin
                play_gate[c] = ~play_gate[c];
                play_cnt[c]  = '0;
            end
            if (pre_cnt[c] >= CNT_W'(prescale)) begin
                play_cnt[c] = play_cnt[c] + 1'b1;
                pre_cnt[c]  = '0;
            end
            pre_cnt[c] = pre_cnt[c] + 1'b1;
            if (!play_gate[c]) begin
                tone_lvl[c] = 1'b0;
            end else begin
                if (len_cnt[c] >= CNT_W'(len_per[c])) begin
                    len_gate[c] = ~len_gate[c];
                    len_cnt[c]  = '0;
                end
                len_cnt[c] = len_cnt[c] + 1'b1;
                if (!len_gate[c]) begin
                    tone_lvl[c] = 1'b0;
                end else begin
                    if (tone_cnt[c] >= CNT_W'(tone_per[c])) begin
                        tone_lvl[c] = ~tone_lvl[c];
                        tone_cnt[c] = '0;
                    end
                    tone_cnt[c] = tone_cnt[c] + 1'b1;
                end
            end
            level = level ^ tone_lvl[c];
        end
    endtask

    task automatic reload_periods();
        logic [DRAW_W-1:0] d;
        t_set              pick;
        int                row;
        if (press_total > TOTAL_WRAP) begin
            press_total = '0;
        end
        draw_value(d);
        press_total = press_total + TOTAL_W'(d / TOTAL_DIV);
        if (press_total[1:0] == 2'b00) begin
            pick = SET_A;
        end else if (!press_total[0]) begin
            pick = SET_B;
        end else if (press_total % 3 == 0) begin
            pick = SET_C;
        end else begin
            pick = SET_D;
        end
        for (int c = CHANNELS - 1; c >= 0; c--) begin
            row = (c > 2) ? 2 : c;
            draw_value(d);
            tone_per[c] = PER_W'(d / DIVISORS[pick][row][0]);
            draw_value(d);
            len_per[c]  = PER_W'(d / DIVISORS[pick][row][1]);
            draw_value(d);
            play_per[c] = PER_W'(d / DIVISORS[pick][row][2]);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            restore_reset();
            expected_levels.delete();
        end else begin
            if (i_psel && i_penable && i_pready) begin
                if (i_pwrite) begin
                    if (i_paddr == PRESCALE_ADDR) begin
                        prescale = i_pwdata[PER_W-1:0];
                    end
                end else if (i_paddr == PRESCALE_ADDR) begin
                    if (i_prdata[PER_W-1:0] !== prescale) begin
                        report_mismatch("play_prescale readback", prescale, i_prdata[PER_W-1:0]);
                    end
                end
            end
            if (i_tick.valid && i_tick.ready) begin
                tick_channels(predicted);
                expected_levels.push_back(predicted);
                if (i_tick.button_pressed) begin
                    reload_periods();
                end
            end
            if (i_level.valid && i_level.ready) begin
                if (expected_levels.size() == 0) begin
                    report_mismatch("unexpected noise_level", -1, i_level.noise_level);
                end else begin
                    wanted = expected_levels.pop_front();
                    if (i_level.noise_level !== wanted) begin
                        report_mismatch("noise_level", wanted, i_level.noise_level);
                    end
                end
            end
        end
        o_pending = expected_levels.size();
    end

endmodule

// ===== tb/tb_gated_tone_noise_generator_unit.sv =====
// Testbench top of the gated tone noise generator: drives ticks and button
// presses, stalls the level receiver, programs play_prescale over APB and
// gives the verdict. Depends on gtn_pkg, both interfaces and gtn_noise_checker.
module tb_gated_tone_noise_generator_unit;
    import gtn_pkg::*;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int RELOAD_CYCLES = 4 + 3 * 3 * CHANNELS + 20;
    localparam int PHASE_TICKS   = 130;
    localparam int PHASES        = 5;
    localparam logic [ADDR_W-1:0] PRESCALE_ADDR = ADDR_W'({REG_PLAY_PRESCALE, 2'b00});
    localparam logic [ADDR_W-1:0] SPARE_ADDR    = ADDR_W'({~REG_PLAY_PRESCALE, 2'b00});

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    int                fail_count;
    int                pending_levels;
    int                cycle_count = 0;
    int                ticks_sent = 0;
    int                presses_sent = 0;
    int                settings_used = 0;
    bit                burst_in = 1'b0;
    bit                burst_out = 1'b0;

    gtn_in_if  tick_ch ();
    gtn_out_if level_ch ();

    gated_tone_noise_generator_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (tick_ch),
        .o_out   (level_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    gtn_noise_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_tick       (tick_ch),
        .i_level      (level_ch),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_prdata     (prdata),
        .i_pready     (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending_levels)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles with %0d levels outstanding",
                     cycle_count, pending_levels);
            $display("status: fail");
            $finish;
        end
    end

    // Leaves psel high after the access phase so that a following access can
    // start its setup phase directly.
    task automatic apb_access(input logic write, input logic [ADDR_W-1:0] addr,
                              input logic [DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
    endtask

    // Writes the prescale with random upper bits, then checks that a write
    // outside the register map leaves it unchanged.
    task automatic set_prescale(input logic [PER_W-1:0] value);
        apb_access(1'b1, PRESCALE_ADDR, {16'($urandom()), value});
        apb_access(1'b0, PRESCALE_ADDR, '0);
        apb_access(1'b1, SPARE_ADDR, $urandom());
        apb_access(1'b0, PRESCALE_ADDR, '0);
        psel    <= 1'b0;
        penable <= 1'b0;
        settings_used++;
    endtask

    task automatic send_tick(input bit pressed);
        int gap;
        gap = burst_in ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            tick_ch.valid          <= 1'b0;
            tick_ch.button_pressed <= 1'($urandom_range(0, 1));
            repeat (gap) @(negedge i_clk);
        end
        tick_ch.valid          <= 1'b1;
        tick_ch.button_pressed <= pressed;
        do @(posedge i_clk); while (!tick_ch.ready);
        @(negedge i_clk);
        ticks_sent++;
        if (pressed) begin
            presses_sent++;
        end
    endtask

    // The last level can arrive while a press reload is still running.
    task automatic wait_drained();
        tick_ch.valid <= 1'b0;
        while (pending_levels != 0) @(negedge i_clk);
        repeat (RELOAD_CYCLES) @(negedge i_clk);
    endtask

    initial begin
        level_ch.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            int stall;
            if ($urandom_range(0, 31) == 0) begin
                burst_out = !burst_out;
            end
            stall = burst_out ? 0 : $urandom_range(0, 4);
            if (stall > 0) begin
                level_ch.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            level_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!(level_ch.valid && level_ch.ready));
            @(negedge i_clk);
        end
    end

    initial begin
        logic [PER_W-1:0] value;
        i_rst_n                = 1'b0;
        tick_ch.valid          = 1'b0;
        tick_ch.button_pressed = 1'b0;
        psel                   = 1'b0;
        penable                = 1'b0;
        pwrite                 = 1'b0;
        paddr                  = '0;
        pwdata                 = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Plain ticks at the reset prescale, then, with the prescale at zero,
        // back-to-back presses, alternating presses and plain ticks.
        repeat (3) send_tick(1'b0);
        wait_drained();
        set_prescale('0);
        repeat (6) send_tick(1'b1);
        for (int i = 0; i < 8; i++) begin
            send_tick(1'(i % 2));
        end
        repeat (3) send_tick(1'b0);
        wait_drained();

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0:       value = '1;
                1:       value = PER_W'(1);
                2:       value = PER_W'($urandom_range(2, 65534));
                3:       value = '0;
                default: value = PRESCALE_RST;
            endcase
            set_prescale(value);
            for (int i = 0; i < PHASE_TICKS; i++) begin
                if ($urandom_range(0, 31) == 0) begin
                    burst_in = !burst_in;
                end
                send_tick($urandom_range(0, 9) < 7);
            end
            wait_drained();
        end

        $display("covered %0d ticks, %0d of them with the button pressed, under %0d prescale",
                 ticks_sent, presses_sent, settings_used);
        $display("settings from 0 to 65535, with readback and ignored out-of-map writes");
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
